[src/swm_pkg.sv]
// Shared types and constants for the sliding window median filter.
// Used by swm_cell and sliding_window_median; depends on nothing else.
`default_nettype none
package swm_pkg;

  localparam int DATA_W     = 32;
  localparam int WINDOW_MAX = 64;
  localparam int CFG_W      = 7;
  localparam int AGE_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int IDX_W      = AGE_W;
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1);

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic [AGE_W-1:0]         age_t;
  typedef logic [IDX_W-1:0]         idx_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [CFG_W-1:0]         cfg_t;

  typedef struct packed {
    logic step;
    logic full;
    age_t age_last;
  } cell_ctrl_t;

endpackage
`default_nettype wire

[src/swm_cell.sv]
// One slot of the sorted window: a value, its age and the insert/remove decision.
// Depends on swm_pkg.
`default_nettype none
module swm_cell
  import swm_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire sample_t    key,
  input  wire logic       valid,
  input  wire sample_t    left_val,
  input  wire age_t       left_age,
  input  wire logic       left_gt,
  input  wire sample_t    right_val,
  input  wire age_t       right_age,
  input  wire logic       right_gt,
  input  wire logic       rm_before,
  output logic            gt,
  output logic            rm_seen,
  output sample_t         val,
  output age_t            age
);

  sample_t val_r, val_nxt;
  age_t    age_r, age_nxt;
  logic    rm_self;

  // An empty slot counts as larger than any key, so the insertion point is the first greater slot.
  assign gt      = !valid || (val_r > key);
  assign rm_self = ctrl.full && valid && (age_r == ctrl.age_last);
  assign rm_seen = rm_before || rm_self;
  assign val     = val_r;
  assign age     = age_r;

  always_comb begin
    val_nxt = val_r;
    age_nxt = age_r + age_t'(1);
    if (rm_seen) begin
      if (!right_gt) begin
        val_nxt = right_val;
        age_nxt = right_age + age_t'(1);
      end else if (rm_self ? left_gt : !gt) begin
        if (rm_self) begin
          val_nxt = left_val;
          age_nxt = left_age + age_t'(1);
        end else begin
          val_nxt = key;
          age_nxt = '0;
        end
      end else if (rm_self) begin
        val_nxt = key;
        age_nxt = '0;
      end
    end else if (gt) begin
      if (left_gt) begin
        val_nxt = left_val;
        age_nxt = left_age + age_t'(1);
      end else begin
        val_nxt = key;
        age_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      val_r <= val_nxt;
      age_r <= age_nxt;
    end
  end

endmodule
`default_nettype wire

[src/sliding_window_median.sv]
// Top level of the sliding window median filter: control, cell row and output register.
// Depends on swm_pkg and swm_cell.
//
//   channel  | signals                          | payload (lowest bit up)
//   in       | in_tvalid in_tready in_tdata     | sample[31:0]
//   out      | out_tvalid out_tready out_tdata  | median[31:0]
//   cfg      | cfg_valid cfg_ready cfg_data     | window_size[6:0]
//
// Cells update in the cycle a word is accepted: one per clock while in_tready is high.
// A full window marks a median pending; it is registered onto out once out is free.
// A stalled output holds back input only while a second median is waiting.
// A configuration word waits for a pending median and holds back input while offered.
// Reset empties the window and sets the window size to three.
`default_nettype none
module sliding_window_median
  import swm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [DATA_W-1:0] in_tdata,   // sample
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [DATA_W-1:0]      out_tdata,  // median
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  cnt_t    fill_r, fill_nxt;
  cnt_t    win_r, win_nxt;
  idx_t    rank_r, rank_nxt;
  age_t    last_r, last_nxt;
  logic    pend_r, pend_nxt;
  logic    ovld_r, ovld_nxt;
  sample_t odata_r;
  logic    in_acc, cfg_acc, out_ld, full;
  logic [CNT_W:0] rank_ext;

  cell_ctrl_t ctrl;
  sample_t    vals [WINDOW_MAX];
  age_t       ages [WINDOW_MAX];
  logic       gts  [WINDOW_MAX];
  logic       rms  [WINDOW_MAX+1];

  assign cfg_ready  = !pend_r;
  assign cfg_acc    = cfg_valid && cfg_ready;
  assign in_tready  = !cfg_valid && (!pend_r || !ovld_r || out_tready);
  assign in_acc     = in_tvalid && in_tready;
  assign out_ld     = pend_r && (!ovld_r || out_tready);
  assign full       = (fill_r == win_r);
  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;

  assign ctrl.step     = in_acc;
  assign ctrl.full     = full;
  assign ctrl.age_last = last_r;

  assign rms[0] = 1'b0;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    swm_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .key       (sample_t'(in_tdata)),
      .valid     (fill_r > cnt_t'(i)),
      .left_val  ((i == 0) ? sample_t'(0) : vals[(i == 0) ? 0 : i-1]),
      .left_age  ((i == 0) ? age_t'(0) : ages[(i == 0) ? 0 : i-1]),
      .left_gt   ((i == 0) ? 1'b0 : gts[(i == 0) ? 0 : i-1]),
      .right_val ((i == WINDOW_MAX-1) ? sample_t'(0) :
                  vals[(i == WINDOW_MAX-1) ? i : i+1]),
      .right_age ((i == WINDOW_MAX-1) ? age_t'(0) :
                  ages[(i == WINDOW_MAX-1) ? i : i+1]),
      .right_gt  ((i == WINDOW_MAX-1) ? 1'b1 : gts[(i == WINDOW_MAX-1) ? i : i+1]),
      .rm_before (rms[i]),
      .gt        (gts[i]),
      .rm_seen   (rms[i+1]),
      .val       (vals[i]),
      .age       (ages[i])
    );
  end

  always_comb begin
    win_nxt  = win_r;
    rank_nxt = rank_r;
    last_nxt = last_r;
    fill_nxt = fill_r;
    pend_nxt = pend_r && !out_ld;
    ovld_nxt = out_ld ? 1'b1 : (ovld_r && !out_tready);
    rank_ext = '0;
    if (cfg_acc) begin
      priority if (int'(cfg_data) > WINDOW_MAX) begin
        win_nxt = cnt_t'(WINDOW_MAX);
      end else if (cfg_data == '0) begin
        win_nxt = cnt_t'(1);
      end else begin
        win_nxt = cnt_t'(cfg_data);
      end
      rank_ext = ({1'b0, win_nxt} + (CNT_W+1)'(1)) >> 1;
      rank_nxt = idx_t'(rank_ext - (CNT_W+1)'(1));
      last_nxt = age_t'(win_nxt - cnt_t'(1));
      fill_nxt = '0;
    end else if (in_acc) begin
      if (!full) begin
        fill_nxt = fill_r + cnt_t'(1);
      end
      if (full || (fill_r + cnt_t'(1) == win_r)) begin
        pend_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      win_r  <= cnt_t'(3);
      rank_r <= idx_t'(1);
      last_r <= age_t'(2);
      pend_r <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      win_r  <= win_nxt;
      rank_r <= rank_nxt;
      last_r <= last_nxt;
      pend_r <= pend_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      odata_r <= vals[rank_r];
    end
  end

  a_fill_le_win: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= win_r) else $error("fill count exceeds window size");

  a_rank_in_win: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_t'(rank_r) < win_r) else $error("median rank outside window");

  a_full_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && full && !cfg_acc) |=> pend_r) else $error("full window gave no result");

  a_pend_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && ovld_r && !out_tready) |-> !in_tready)
    else $error("input taken while two results wait");

endmodule
`default_nettype wire

[tb/sliding_window_median_test.sv]
// Self-checking testbench for sliding_window_median: drives samples under varied stalls,
// predicts each lower median from its own sorted copy of the window and checks every word.
// Depends on swm_pkg and the sliding_window_median RTL.
`default_nettype none
module sliding_window_median_test;
  timeunit 1ns;
  timeprecision 1ps;
  import swm_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [DATA_W-1:0] in_tdata = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  cfg_t             cfg_data = '0;

  localparam sample_t MOST_NEG = {1'b1, {(DATA_W-1){1'b0}}};
  localparam sample_t MOST_POS = {1'b0, {(DATA_W-1){1'b1}}};

  sliding_window_median DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Predictor state: the window in ascending order and in arrival order.
  sample_t sorted_win[$];
  sample_t arrival_hist[WINDOW_MAX];
  int      hist_ptr = 0;
  cfg_t    win_setting = 7'd3;
  sample_t median_q[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int samples_sent = 0;
  int medians_seen = 0;
  int settings_used = 1;
  int mismatches = 0;

  function automatic int eff_size(cfg_t v);
    if (v < 1) return 1;
    if (v > WINDOW_MAX) return WINDOW_MAX;
    return int'(v);
  endfunction

  function automatic void window_insert(sample_t s);
    int w;
    int pos;
    w = eff_size(win_setting);
    if (hist_ptr >= w) hist_ptr = 0;
    if (sorted_win.size() > w) sorted_win.delete();
    if (sorted_win.size() == w) begin
      pos = 0;
      while (sorted_win[pos] != arrival_hist[hist_ptr]) pos++;
      sorted_win.delete(pos);
    end
    pos = 0;
    while (pos < sorted_win.size() && sorted_win[pos] <= s) pos++;
    sorted_win.insert(pos, s);
    arrival_hist[hist_ptr] = s;
    hist_ptr++;
    if (hist_ptr >= w) hist_ptr = 0;
    if (sorted_win.size() == w) median_q.insert(median_q.size(), sorted_win[(w + 1) / 2 - 1]);
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(9))
      5, 6, 7: return sample_t'(int'($urandom_range(8)) - 4);
      8, 9: begin
        case ($urandom_range(3))
          0: return MOST_NEG;
          1: return MOST_POS;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    window_insert(s);
    samples_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (median_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_window(input cfg_t v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    win_setting = v;
    sorted_win.delete();
    hist_ptr = 0;
    settings_used++;
  endtask

  // Result checker and receiver stall generator.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_tvalid && out_tready) begin
      medians_seen++;
      if (median_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected median word %0d", $signed(out_tdata));
      end else begin
        if (sample_t'(out_tdata) !== median_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("median mismatch: expected %0d, got %0d", median_q[0],
                     $signed(out_tdata));
        end
        void'(median_q.pop_front());
      end
    end
  end

  task automatic test_default_window();
    sample_t vals[13];
    vals = '{MOST_POS, MOST_NEG, 0, -1, 1, 5, 5, 5, MOST_NEG, MOST_NEG, MOST_POS,
             MOST_POS, -1};
    foreach (vals[i]) send_sample(vals[i]);
  endtask

  task automatic test_size_limits();
    write_window(7'd0);
    send_sample(sample_t'(32'h5555_5555));
    send_sample(sample_t'(32'hAAAA_AAAA));
    send_sample(-7);
    write_window(7'd127);
    send_sample(3);
    send_sample(MOST_NEG);
    send_sample(-3);
    write_window(7'd2);
    send_sample(9);
    send_sample(-9);
    send_sample(-9);
    send_sample(MOST_POS);
  endtask

  task automatic test_random_windows(input int budget, input cfg_t first_size);
    cfg_t v;
    int   w;
    int   n;
    int   sent;
    bit   first;
    sent  = 0;
    first = 1'b1;
    while (sent < budget) begin
      if (first) v = first_size;
      else begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: v = cfg_t'($urandom_range(8, 1));
          5, 6, 7: v = cfg_t'($urandom_range(WINDOW_MAX, 9));
          8: v = cfg_t'($urandom_range(127, WINDOW_MAX + 1));
          default: v = '0;
        endcase
      end
      first = 1'b0;
      write_window(v);
      w = eff_size(v);
      if ($urandom_range(5) == 0) n = $urandom_range(w - 1);
      else n = w + $urandom_range(20, 1);
      repeat (n) send_sample(rand_sample());
      sent += n;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 28;
    recv_idle_pct = 69;
    test_default_window();
    test_size_limits();
    test_random_windows(180, 7'd64);
    send_idle_pct = 69;
    recv_idle_pct = 28;
    test_random_windows(180, 7'd127);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_windows(190, 7'd1);
    drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d samples over %0d window settings, checked %0d medians.",
             samples_sent, settings_used, medians_seen);
    $display("Mismatches: %0d, medians still expected: %0d.", mismatches,
             median_q.size());
    if (mismatches == 0 && median_q.size() == 0) begin
      $display("PASS sliding_window_median");
    end else begin
      $display("FAIL sliding_window_median");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL sliding_window_median");
    $finish;
  end

endmodule
`default_nettype wire
